// ----- design/array_shuffle_engine_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the array shuffle engine
// Shared property templates, all clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ARRAY_SHUFFLE_ENGINE_MACROS_SVH
`define ARRAY_SHUFFLE_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("array shuffle engine: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define ASE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array shuffle engine: next-cycle property violated");

`endif

// ----- design/ase_pkg.sv -----
// ----------------------------------------------------------------------------
// Array shuffle engine package
// Sizes, command codes and the request and result types of the engine.
// ----------------------------------------------------------------------------
package ase_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int DATA_W  = 32;

    // Feedback mask of the right-shifting Galois generator, taps 32, 22, 2, 1.
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    // The last code is accepted and ignored by the engine.
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_EMIT    = 2'd1,
        CMD_SHUFFLE = 2'd2,
        CMD_IGNORED = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic [ADDR_W-1:0]        index;
        logic                     final_item;
    } res_t;

endpackage

// ----- design/array_shuffle_engine.sv -----
// ----------------------------------------------------------------------------
// Array shuffle engine
// Loads an array of signed words, emits it in order or as a Fisher-Yates
// permutation drawn from a seeded 32-bit Galois LFSR.
// ----------------------------------------------------------------------------
// The engine takes one request at a time. A load request (command 0) writes
// one element into the original store; the request with last set closes
// the array, and the next load starts a new one. Loads beyond 64 elements
// are dropped. An emit request (command 1) returns the original array, one
// result per element. A shuffle request (command 2) copies the original
// into the working store, then runs len-1 swap steps, and emits the
// permutation. The swap step is dominated by the bit-serial remainder
// unit, which retires one quotient bit per cycle over the 32 bits of the
// random word; the rest of the step is the generator step and the four
// single-port accesses of the swap. An empty array produces no results,
// and command 3 is ignored. While an item is at work req_stall stays high.
// Results pass through an output register, so the engine finishes a run
// and takes the next request while the final result still waits on
// res_stall. A write on the configuration port loads the generator seed
// (a zero seed becomes 1) and should be issued only while the engine is
// idle; cfg_ready is always high.
module array_shuffle_engine (
    input  logic          clk,
    input  logic          rst_n,
    // request channel
    input  logic          req_valid,
    output logic          req_stall,
    input  ase_pkg::req_t req,
    // result channel
    output logic          res_valid,
    input  logic          res_stall,
    output ase_pkg::res_t res,
    // seed write channel
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_RAND,
        ST_DIV,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_EM_RD,
        ST_EM_PUT
    } state_t;

    localparam int AW = ase_pkg::ADDR_W;
    localparam int LW = ase_pkg::LEN_W;
    localparam int DW = ase_pkg::DATA_W;

    state_t state_reg;

    // Array bookkeeping.
    logic [LW-1:0] len_reg;
    logic          load_open_reg;
    logic [AW-1:0] k_reg;          // copy and emit position
    logic [AW-1:0] i_reg;          // swap step
    logic          src_work_reg;   // emit reads the working store

    // Random generator and remainder unit.
    logic [31:0]   rand_reg;
    logic [31:0]   div_reg;
    logic [LW-1:0] rem_reg;
    logic [LW-1:0] divisor_reg;
    logic [4:0]    cnt_reg;

    logic [DW-1:0] tmp_reg;
    ase_pkg::res_t res_reg;
    logic          res_valid_reg;

    // Memories and their registered read data.
    logic [DW-1:0] orig_mem [ase_pkg::MAX_LEN];
    logic [DW-1:0] work_mem [ase_pkg::MAX_LEN];
    logic [DW-1:0] orig_rd_reg;
    logic [DW-1:0] work_rd_reg;

    logic          orig_we;
    logic [AW-1:0] orig_waddr;
    logic          work_we;
    logic [AW-1:0] work_waddr;
    logic [DW-1:0] work_wdata;
    logic [AW-1:0] work_raddr;

    logic          req_accept;
    logic          out_free;
    logic [LW-1:0] eff_len;
    logic [31:0]   lfsr_step;
    logic [31:0]   seed_fixed;
    logic [LW:0]   trial;
    logic [LW:0]   trial_diff;
    logic          trial_ge;
    logic [LW-1:0] rem_step;
    logic [AW-1:0] j_addr;
    logic          k_is_last;
    logic          i_is_last;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // The output slot is free when empty or when its result leaves this cycle.
    assign out_free = !res_valid_reg || !res_stall;

    // A load on a closed array starts over from position zero.
    assign eff_len = load_open_reg ? len_reg : '0;

    assign lfsr_step  = {1'b0, rand_reg[31:1]} ^ (rand_reg[0] ? ase_pkg::LFSR_MASK : 32'd0);
    assign seed_fixed = (cfg_data == 32'd0) ? 32'd1 : cfg_data;

    // One restoring division step: shift in the next dividend bit and
    // subtract the divisor when it fits. The remainder stays below the
    // divisor, which is at most MAX_LEN.
    assign trial      = {rem_reg, div_reg[31]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = (trial >= {1'b0, divisor_reg});
    assign rem_step   = trial_ge ? trial_diff[LW-1:0] : trial[LW-1:0];

    assign j_addr    = i_reg + rem_reg[AW-1:0];
    assign k_is_last = (({1'b0, k_reg} + LW'(1)) == len_reg);
    assign i_is_last = (({1'b0, i_reg} + LW'(2)) >= len_reg);

    always_comb
    begin
        orig_we    = req_accept && (req.cmd == ase_pkg::CMD_LOAD) &&
                     (eff_len < LW'(ase_pkg::MAX_LEN));
        orig_waddr = eff_len[AW-1:0];

        work_we    = 1'b0;
        work_waddr = k_reg;
        work_wdata = orig_rd_reg;
        unique case (state_reg)
            ST_COPY_WR:
            begin
                work_we = 1'b1;
            end
            ST_WR_I:
            begin
                work_we    = 1'b1;
                work_waddr = i_reg;
                work_wdata = work_rd_reg;
            end
            ST_WR_J:
            begin
                work_we    = 1'b1;
                work_waddr = j_addr;
                work_wdata = tmp_reg;
            end
            default:
            begin
                work_we = 1'b0;
            end
        endcase

        unique case (state_reg)
            ST_RD_I: work_raddr = i_reg;
            ST_RD_J: work_raddr = j_addr;
            default: work_raddr = k_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (orig_we)
        begin
            orig_mem[orig_waddr] <= req.value;
        end
        orig_rd_reg <= orig_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        work_rd_reg <= work_mem[work_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            load_open_reg <= 1'b0;
            rand_reg      <= 32'd1;
            res_valid_reg <= 1'b0;
            k_reg         <= '0;
            i_reg         <= '0;
            src_work_reg  <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            // A new result fills the slot; otherwise an accepted one empties it.
            if ((state_reg == ST_EM_PUT) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                rand_reg <= seed_fixed;
            end
            else if (state_reg == ST_RAND)
            begin
                rand_reg <= lfsr_step;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    k_reg <= '0;
                    i_reg <= '0;
                    if (req_accept)
                    begin
                        unique case (req.cmd)
                            ase_pkg::CMD_LOAD:
                            begin
                                if (eff_len < LW'(ase_pkg::MAX_LEN))
                                begin
                                    len_reg <= eff_len + LW'(1);
                                end
                                else
                                begin
                                    len_reg <= eff_len;
                                end
                                load_open_reg <= !req.last;
                            end
                            ase_pkg::CMD_EMIT:
                            begin
                                src_work_reg <= 1'b0;
                                if (len_reg != '0)
                                begin
                                    state_reg <= ST_EM_RD;
                                end
                            end
                            ase_pkg::CMD_SHUFFLE:
                            begin
                                src_work_reg <= 1'b1;
                                if (len_reg != '0)
                                begin
                                    state_reg <= ST_COPY_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_COPY_RD:
                begin
                    state_reg <= ST_COPY_WR;
                end

                ST_COPY_WR:
                begin
                    if (k_is_last)
                    begin
                        k_reg <= '0;
                        state_reg <= (len_reg > LW'(1)) ? ST_RAND : ST_EM_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= ST_COPY_RD;
                    end
                end

                ST_RAND:
                begin
                    div_reg     <= lfsr_step;
                    rem_reg     <= '0;
                    divisor_reg <= len_reg - {1'b0, i_reg};
                    cnt_reg     <= '0;
                    state_reg   <= ST_DIV;
                end

                ST_DIV:
                begin
                    rem_reg <= rem_step;
                    div_reg <= {div_reg[30:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_RD_I;
                    end
                end

                ST_RD_I:
                begin
                    state_reg <= ST_RD_J;
                end

                ST_RD_J:
                begin
                    tmp_reg   <= work_rd_reg;
                    state_reg <= ST_WR_I;
                end

                ST_WR_I:
                begin
                    state_reg <= ST_WR_J;
                end

                ST_WR_J:
                begin
                    if (i_is_last)
                    begin
                        state_reg <= ST_EM_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + AW'(1);
                        state_reg <= ST_RAND;
                    end
                end

                ST_EM_RD:
                begin
                    state_reg <= ST_EM_PUT;
                end

                ST_EM_PUT:
                begin
                    if (out_free)
                    begin
                        res_reg.value_res  <= src_work_reg ? work_rd_reg : orig_rd_reg;
                        res_reg.index      <= k_reg;
                        res_reg.final_item <= k_is_last;
                        if (k_is_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + AW'(1);
                            state_reg <= ST_EM_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/ase_checker.sv -----
// ----------------------------------------------------------------------------
// Array shuffle engine checker
// Port-level properties of the engine, bound to every instance of it.
// ----------------------------------------------------------------------------
`include "array_shuffle_engine_macros.svh"

module ase_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input ase_pkg::req_t req,
    input logic          res_valid,
    input logic          res_stall,
    input ase_pkg::res_t res
);

    logic load_accept;
    logic mid_run;

    // A load request, or an unused command, never makes the engine busy.
    assign load_accept = req_valid && !req_stall &&
                         ((req.cmd == ase_pkg::CMD_LOAD) ||
                          (req.cmd == ase_pkg::CMD_IGNORED));

    // A result that is not the final one of its run means the run goes on.
    assign mid_run = res_valid && !res.final_item;

    `ASE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
    `ASE_ASSERT_NEXT(a_load_single_cycle, load_accept, !req_stall)
    `ASE_ASSERT_SAME(a_busy_mid_run, mid_run, req_stall)

endmodule

bind array_shuffle_engine ase_checker u_ase_checker (.*);
